>>> rtl/tts_pkg.sv
// Shared types, constants and register indexes of the timed turn-and-drive sequencer.
`default_nettype none

package tts_pkg;

	// Binary angle width (full circle = 2**ANGLE_BITS) and phase counter width.
	localparam int ANGLE_BITS = 16;
	localparam int COUNT_BITS = 32;

	// Fixed field widths.
	localparam int FIELD_BITS = 16;
	localparam int CFG_BITS   = 32;
	localparam int DUTY_BITS  = 10;
	localparam int CFG_IDX_BITS = 4;

	// Fractional bits of the distance scale register.
	localparam int DIST_FRAC_BITS = 16;

	// Product widths before the fixed-point shift.
	localparam int TURN_PROD_BITS  = ANGLE_BITS + CFG_BITS;
	localparam int DRIVE_PROD_BITS = FIELD_BITS + CFG_BITS;

	// Largest phase count, held in a 64-bit word for comparisons.
	localparam logic [63:0] COUNT_MAX = 64'((65'd1 << COUNT_BITS) - 65'd1);

	// Register reset values.
	localparam logic [CFG_BITS-1:0]  PAUSE_RESET = 32'd112500000;
	localparam logic [DUTY_BITS-1:0] DUTY_RESET  = 10'd512;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] CFG_TICKS_PER_REV  = 4'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TICKS_PER_DIST = 4'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PAUSE_TICKS    = 4'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DRIVE_DUTY     = 4'd3;

	typedef logic [ANGLE_BITS-1:0] angle_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [DUTY_BITS-1:0]  duty_t;

	// Movement phase.
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_TURN  = 2'd1,
		PH_PAUSE = 2'd2,
		PH_DRIVE = 2'd3
	} phase_t;

	// Configuration register contents.
	typedef struct packed {
		logic [CFG_BITS-1:0] ticks_per_revolution;
		logic [CFG_BITS-1:0] ticks_per_distance;
		logic [CFG_BITS-1:0] pause_ticks;
		duty_t               drive_duty;
	} cfg_t;

	// One input item.
	typedef struct packed {
		logic                  cmd;
		logic [FIELD_BITS-1:0] pose_angle;
		logic [FIELD_BITS-1:0] target_heading;
		logic [FIELD_BITS-1:0] travel_distance;
	} item_t;

	// One result item.
	typedef struct packed {
		duty_t      pwm_left;
		duty_t      pwm_right;
		logic       forward;
		logic [1:0] phase;
		logic       busy_res;
		logic       rejected;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/tts_cfg.sv
// Configuration register file of the timed turn-and-drive sequencer.
`default_nettype none

module tts_cfg
	import tts_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [CFG_BITS-1:0]     cfg_data,
	output cfg_t                         cfg
);

	cfg_t cfg_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Register writes; indexes beyond the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_revolution <= '0;
			cfg_q.ticks_per_distance   <= '0;
			cfg_q.pause_ticks          <= PAUSE_RESET;
			cfg_q.drive_duty           <= DUTY_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TICKS_PER_REV:  cfg_q.ticks_per_revolution <= cfg_data;
				CFG_TICKS_PER_DIST: cfg_q.ticks_per_distance   <= cfg_data;
				CFG_PAUSE_TICKS:    cfg_q.pause_ticks          <= cfg_data;
				CFG_DRIVE_DUTY:     cfg_q.drive_duty           <= cfg_data[DUTY_BITS-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/tts_core.sv
// Phase state machine, tick countdown and turn/drive length arithmetic.
`default_nettype none

module tts_core
	import tts_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  adv,
	input  wire item_t item,
	input  wire cfg_t  cfg,
	output result_t    result
);

	phase_t phase_q, phase_n;
	count_t remaining_q, remaining_n;
	count_t pending_q, pending_n;
	duty_t  left_q, left_n;
	duty_t  right_q, right_n;
	logic   dir_q, dir_n;

	angle_t pose, head, h_diff, p_diff, turn_angle;
	duty_t  turn_left, turn_right;
	logic [TURN_PROD_BITS-1:0]  turn_prod, turn_shift;
	logic [DRIVE_PROD_BITS-1:0] drive_prod, drive_shift;
	count_t turn_ticks, drive_ticks, pause_count, pending_eff, rem_dec;
	logic   cmd_start, tick, rejected, begin_ph;
	phase_t start_ph;
	count_t start_cnt;

	// Angle differences and the shorter way round.
	assign pose       = angle_t'(item.pose_angle);
	assign head       = angle_t'(item.target_heading);
	assign h_diff     = head - pose;
	assign p_diff     = pose - head;
	assign turn_angle = (h_diff >= p_diff) ? p_diff : h_diff;
	assign turn_left  = (h_diff >= p_diff) ? '0 : cfg.drive_duty;
	assign turn_right = (h_diff >= p_diff) ? cfg.drive_duty : '0;

	// Turn and drive lengths, truncated and saturated to the counter width.
	assign turn_prod   = TURN_PROD_BITS'(turn_angle) * TURN_PROD_BITS'(cfg.ticks_per_revolution);
	assign turn_shift  = turn_prod >> ANGLE_BITS;
	assign drive_prod  = DRIVE_PROD_BITS'(item.travel_distance)
		* DRIVE_PROD_BITS'(cfg.ticks_per_distance);
	assign drive_shift = drive_prod >> DIST_FRAC_BITS;
	assign turn_ticks  = (64'(turn_shift) > COUNT_MAX) ? count_t'(COUNT_MAX)
		: count_t'(turn_shift);
	assign drive_ticks = (64'(drive_shift) > COUNT_MAX) ? count_t'(COUNT_MAX)
		: count_t'(drive_shift);
	assign pause_count = (64'(cfg.pause_ticks) > COUNT_MAX) ? count_t'(COUNT_MAX)
		: count_t'(cfg.pause_ticks);

	// Item classification.
	assign cmd_start   = adv && item.cmd && (phase_q == PH_IDLE);
	assign tick        = adv && !item.cmd && (phase_q != PH_IDLE);
	assign rejected    = item.cmd && (phase_q != PH_IDLE);
	assign pending_eff = cmd_start ? drive_ticks : pending_q;
	assign rem_dec     = (remaining_q != '0) ? remaining_q - count_t'(1) : '0;

	// Which phase is asked to begin, and with what count.
	always_comb begin
		begin_ph  = 1'b0;
		start_ph  = PH_IDLE;
		start_cnt = '0;
		if (cmd_start) begin
			begin_ph = 1'b1;
			if (h_diff == '0) begin
				start_ph  = PH_DRIVE;
				start_cnt = drive_ticks;
			end else begin
				start_ph  = PH_TURN;
				start_cnt = turn_ticks;
			end
		end else if (tick && rem_dec == '0) begin
			begin_ph = 1'b1;
			case (phase_q)
				PH_TURN: begin
					start_ph  = PH_PAUSE;
					start_cnt = pause_count;
				end
				PH_PAUSE: begin
					start_ph  = PH_DRIVE;
					start_cnt = pending_q;
				end
				default: begin
					start_ph  = PH_IDLE;
					start_cnt = '0;
				end
			endcase
		end
	end

	// Next state: a phase with a zero count is skipped at once.
	always_comb begin
		phase_n     = phase_q;
		remaining_n = tick ? rem_dec : remaining_q;
		if (begin_ph) begin
			case (start_ph)
				PH_TURN: begin
					if (start_cnt != '0) begin
						phase_n     = PH_TURN;
						remaining_n = start_cnt;
					end else if (pause_count != '0) begin
						phase_n     = PH_PAUSE;
						remaining_n = pause_count;
					end else if (pending_eff != '0) begin
						phase_n     = PH_DRIVE;
						remaining_n = pending_eff;
					end else begin
						phase_n     = PH_IDLE;
						remaining_n = '0;
					end
				end
				PH_PAUSE: begin
					if (start_cnt != '0) begin
						phase_n     = PH_PAUSE;
						remaining_n = start_cnt;
					end else if (pending_eff != '0) begin
						phase_n     = PH_DRIVE;
						remaining_n = pending_eff;
					end else begin
						phase_n     = PH_IDLE;
						remaining_n = '0;
					end
				end
				PH_DRIVE: begin
					if (start_cnt != '0) begin
						phase_n     = PH_DRIVE;
						remaining_n = start_cnt;
					end else begin
						phase_n     = PH_IDLE;
						remaining_n = '0;
					end
				end
				default: begin
					phase_n     = PH_IDLE;
					remaining_n = '0;
				end
			endcase
		end
	end

	// Wheel duties and direction for the phase being entered.
	always_comb begin
		left_n    = left_q;
		right_n   = right_q;
		pending_n = cmd_start ? drive_ticks : pending_q;
		dir_n     = dir_q | cmd_start;
		if (begin_ph) begin
			case (phase_n)
				PH_TURN: begin
					left_n  = turn_left;
					right_n = turn_right;
				end
				PH_DRIVE: begin
					left_n  = cfg.drive_duty;
					right_n = cfg.drive_duty;
				end
				default: begin
					left_n  = '0;
					right_n = '0;
				end
			endcase
		end
	end

	// State registers, updated once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			remaining_q <= '0;
			pending_q   <= '0;
			left_q      <= '0;
			right_q     <= '0;
			dir_q       <= 1'b0;
		end else if (adv) begin
			phase_q     <= phase_n;
			remaining_q <= remaining_n;
			pending_q   <= pending_n;
			left_q      <= left_n;
			right_q     <= right_n;
			dir_q       <= dir_n;
		end
	end

	// Result of the item: state after its update.
	assign result.pwm_left  = left_n;
	assign result.pwm_right = right_n;
	assign result.forward   = dir_n;
	assign result.phase     = 2'(phase_n);
	assign result.busy_res  = (phase_n != PH_IDLE);
	assign result.rejected  = rejected;

`ifndef SYNTH
	// A running phase always has ticks left.
	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> (remaining_q != '0))
		else $error("running phase with zero count");

	// Idle and pause leave both wheels stopped.
	a_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE || phase_q == PH_PAUSE) |-> (left_q == '0 && right_q == '0))
		else $error("wheel duty set while stopped");

	// A command taken while busy leaves the phase and count untouched.
	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item.cmd && phase_q != PH_IDLE)
		|=> (phase_q == $past(phase_q) && remaining_q == $past(remaining_q)))
		else $error("rejected command changed the move");

	// Moving implies the direction bit is set.
	a_forward: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) |-> dir_q)
		else $error("moving without direction bit");
`endif

endmodule

`default_nettype wire

>>> rtl/timed_turn_and_drive_sequencer_top.sv
// Top level of the timed turn-and-drive sequencer: channels, item and result registers.
//
// Usage: items arrive on the cmd channel (cmd_valid/cmd_ready); an item is either a
// timer tick (cmd = 0) or a move command (cmd = 1) with pose, heading and distance.
// Every item gives exactly one result on the res channel (res_valid/res_ready) with
// the wheel duties, direction, phase, busy flag and the rejected flag.
// Registers are written on the cfg channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data); cfg_ready is always high and writes belong to idle periods.
// An item taken into the item register passes through the phase logic into the
// result register, and res_valid rises when the result register is written.
// Throughput: one item per cycle while the receiver keeps up; the phase state and
// both fixed-point products are updated by one pass of logic between the item
// register and the result register.
// A stalled receiver holds the result register; the item register then fills and
// cmd_ready drops until res_ready returns, so nothing is lost or repeated.
// Reset clears the phase to idle, all counts and duties to zero, the direction bit,
// and loads the register reset values (pause 112500000 ticks, duty 512).
`default_nettype none

module timed_turn_and_drive_sequencer_top
	import tts_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cmd_valid,
	output logic                         cmd_ready,
	input  wire logic                    cmd,
	input  wire logic [FIELD_BITS-1:0]   pose_angle,
	input  wire logic [FIELD_BITS-1:0]   target_heading,
	input  wire logic [FIELD_BITS-1:0]   travel_distance,
	output logic                         res_valid,
	input  wire logic                    res_ready,
	output logic [DUTY_BITS-1:0]         pwm_left,
	output logic [DUTY_BITS-1:0]         pwm_right,
	output logic                         forward,
	output logic [1:0]                   phase,
	output logic                         busy_res,
	output logic                         rejected,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [CFG_BITS-1:0]     cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t result;
	result_t res_q;
	logic    res_valid_q;
	logic    adv;

	// Configuration registers.
	tts_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The held item moves on whenever the result register is free or being emptied.
	assign adv       = valid_s1 && (!res_valid_q || res_ready);
	assign cmd_ready = !valid_s1 || adv;

	// Item register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			item_s1.cmd             <= cmd;
			item_s1.pose_angle      <= pose_angle;
			item_s1.target_heading  <= target_heading;
			item_s1.travel_distance <= travel_distance;
		end
	end

	// Sequencer state and next-state logic.
	tts_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= result;
		end
	end

	// Result ports.
	assign res_valid = res_valid_q;
	assign pwm_left  = res_q.pwm_left;
	assign pwm_right = res_q.pwm_right;
	assign forward   = res_q.forward;
	assign phase     = res_q.phase;
	assign busy_res  = res_q.busy_res;
	assign rejected  = res_q.rejected;

endmodule

`default_nettype wire
